// ----- rtl/mbuep_pkg.sv -----
package mbuep_pkg;

  // code index numbers of the event packet header
  localparam logic [3:0] CIN_SYSCOM_2B   = 4'h2;
  localparam logic [3:0] CIN_SYSCOM_3B   = 4'h3;
  localparam logic [3:0] CIN_SYSEX_CONT  = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;
  localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

  // status nibbles and bytes of interest
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_CTRL       = 4'hB;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [3:0] HI_PITCH      = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_RT_FIRST    = 8'hF8;

  localparam int unsigned CableCountW = 5;

  // outcome codes
  localparam logic OUTCOME_PACKET = 1'b0;
  localparam logic OUTCOME_REJECT = 1'b1;

  // partial packet state
  typedef struct packed {
    logic       sysex;
    logic [3:0] hdr_cable;
    logic [3:0] hdr_cin;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] fill;
    logic [1:0] target;
  } pack_state_t;

  typedef struct packed {
    logic       outcome;
    logic [3:0] cable_out;
    logic [3:0] code_index;
    logic [7:0] midi_0;
    logic [7:0] midi_1;
    logic [7:0] midi_2;
  } event_t;

endpackage

// ----- rtl/mbuep_byte_if.sv -----
interface mbuep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] cable;

  modport source (output valid, output data_byte, output cable, input ready);
  modport sink   (input valid, input data_byte, input cable, output ready);
endinterface

// ----- rtl/mbuep_event_if.sv -----
interface mbuep_event_if;
  logic       valid;
  logic       ready;
  logic       outcome;
  logic [3:0] cable_out;
  logic [3:0] code_index;
  logic [7:0] midi_0;
  logic [7:0] midi_1;
  logic [7:0] midi_2;

  modport source (
    output valid, output outcome, output cable_out, output code_index,
    output midi_0, output midi_1, output midi_2, input ready
  );
  modport sink (
    input valid, input outcome, input cable_out, input code_index,
    input midi_0, input midi_1, input midi_2, output ready
  );
endinterface

// ----- rtl/mbuep_encode.sv -----
module mbuep_encode (
  input  logic [7:0]                         data_byte_i,
  input  logic [3:0]                         cable_i,
  input  logic [mbuep_pkg::CableCountW-1:0]  cable_count_i,
  input  mbuep_pkg::pack_state_t             state_i,
  output mbuep_pkg::pack_state_t             state_o,
  output logic                               res_valid_o,
  output mbuep_pkg::event_t                  res_o
);

  logic [3:0] hi;
  logic       reject;
  logic       rt_byte;
  logic [3:0] cin;
  logic [1:0] need;
  logic       sysex_set;
  logic       sysex_clr;
  logic [1:0] new_fill;
  logic       sysex_end;

  assign hi       = data_byte_i[7:4];
  assign reject   = {1'b0, cable_i} >= cable_count_i;
  assign rt_byte  = data_byte_i >= mbuep_pkg::BYTE_RT_FIRST;
  assign new_fill = state_i.fill + 2'd1;
  assign sysex_end = state_i.sysex && (data_byte_i == mbuep_pkg::BYTE_SYSEX_END);

  // classify a byte at packet start
  always_comb begin
    cin       = mbuep_pkg::CIN_SINGLE_BYTE;
    need      = 2'd1;
    sysex_set = 1'b0;
    sysex_clr = 1'b0;
    priority if (state_i.sysex) begin
      if (data_byte_i == mbuep_pkg::BYTE_SYSEX_END) begin
        cin       = mbuep_pkg::CIN_SYSEX_END1;
        sysex_clr = 1'b1;
      end else begin
        cin  = mbuep_pkg::CIN_SYSEX_CONT;
        need = 2'd3;
      end
    end else if ((hi >= mbuep_pkg::HI_NOTE_OFF && hi <= mbuep_pkg::HI_CTRL) ||
                 hi == mbuep_pkg::HI_PITCH) begin
      cin  = hi;
      need = 2'd3;
    end else if (hi == mbuep_pkg::HI_PROG || hi == mbuep_pkg::HI_CHAN_PRESS) begin
      cin  = hi;
      need = 2'd2;
    end else if (hi == mbuep_pkg::HI_SYSTEM) begin
      priority if (data_byte_i == mbuep_pkg::BYTE_SYSEX_START) begin
        cin       = mbuep_pkg::CIN_SYSEX_CONT;
        need      = 2'd3;
        sysex_set = 1'b1;
      end else if (data_byte_i == mbuep_pkg::BYTE_MTC_QFRAME ||
                   data_byte_i == mbuep_pkg::BYTE_SONG_SEL) begin
        cin  = mbuep_pkg::CIN_SYSCOM_2B;
        need = 2'd2;
      end else if (data_byte_i == mbuep_pkg::BYTE_SONG_POS) begin
        cin  = mbuep_pkg::CIN_SYSCOM_3B;
        need = 2'd3;
      end else begin
        cin = mbuep_pkg::CIN_SYSEX_END1;
      end
    end else begin
      cin = mbuep_pkg::CIN_SINGLE_BYTE;
    end
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    priority if (reject) begin
      res_valid_o   = 1'b1;
      res_o.outcome = mbuep_pkg::OUTCOME_REJECT;
    end else if (rt_byte) begin
      res_valid_o      = 1'b1;
      res_o.outcome    = mbuep_pkg::OUTCOME_PACKET;
      res_o.cable_out  = cable_i;
      res_o.code_index = mbuep_pkg::CIN_SINGLE_BYTE;
      res_o.midi_0     = data_byte_i;
    end else if (state_i.fill == 2'd0) begin
      state_o.sysex = (state_i.sysex && !sysex_clr) || sysex_set;
      if (need == 2'd1) begin
        res_valid_o      = 1'b1;
        res_o.cable_out  = cable_i;
        res_o.code_index = cin;
        res_o.midi_0     = data_byte_i;
      end else begin
        state_o.hdr_cable = cable_i;
        state_o.hdr_cin   = cin;
        state_o.b0        = data_byte_i;
        state_o.b1        = '0;
        state_o.fill      = 2'd1;
        state_o.target    = need;
      end
    end else begin
      // continuing packet: append the byte (rejected and real-time bytes never get here)
      if (sysex_end || new_fill >= state_i.target) begin
        res_valid_o      = 1'b1;
        res_o.cable_out  = state_i.hdr_cable;
        res_o.code_index = state_i.hdr_cin;
        if (sysex_end) begin
          res_o.code_index = (new_fill == 2'd2) ? mbuep_pkg::CIN_SYSEX_END2
                                                : mbuep_pkg::CIN_SYSEX_END3;
          state_o.sysex    = 1'b0;
        end
        res_o.midi_0   = state_i.b0;
        res_o.midi_1   = (state_i.fill == 2'd1) ? data_byte_i : state_i.b1;
        res_o.midi_2   = (new_fill == 2'd3) ? data_byte_i : 8'h00;
        state_o.fill   = 2'd0;
        state_o.target = 2'd0;
      end else begin
        state_o.b1   = data_byte_i;
        state_o.fill = new_fill;
      end
    end
  end

endmodule

// ----- rtl/midi_byte_to_usb_event_packer.sv -----
// midi byte stream to usb-midi event packet packer
//
// byte_i carries one midi byte and its virtual cable per transfer; evt_o
// carries one event packet per transfer: header nibbles (cable, code index)
// and three midi bytes, unused ones zero, or a reject marker for a cable
// at or above the cable count register (cfg_we_i / cfg_wdata_i, reset 1)
//
// a byte held in the input register is encoded and its packet is captured in
// the output register when the input register advances; bytes that only extend
// a partial packet give no transfer. throughput: one byte per cycle while evt_o
// is not stalled, set by the single encode stage between the input and output registers
//
// reset clears the partial packet, the sysex flag and both valid flags
// when the receiver stalls the output register holds its packet; the input
// register stays full and byte_i.ready drops until the output slot frees
module midi_byte_to_usb_event_packer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mbuep_byte_if.sink                          byte_i,
  mbuep_event_if.source                       evt_o,
  input  logic                                cfg_we_i,
  input  logic [mbuep_pkg::CableCountW-1:0]   cfg_wdata_i
);

  // cable count register
  logic [mbuep_pkg::CableCountW-1:0] cable_count_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [3:0] in_cable_q;

  // partial packet state
  mbuep_pkg::pack_state_t state_q, state_d;

  // output register
  logic              out_valid_q, out_valid_d;
  mbuep_pkg::event_t out_q;

  logic              res_valid;
  mbuep_pkg::event_t res;
  logic              advance;

  // the input register moves on when the output slot is free or emptying
  assign advance      = in_valid_q && (!out_valid_q || evt_o.ready);
  assign byte_i.ready = !in_valid_q || advance;
  assign out_valid_d  = advance ? res_valid : (out_valid_q && !evt_o.ready);

  mbuep_encode u_encode (
    .data_byte_i   (in_byte_q),
    .cable_i       (in_cable_q),
    .cable_count_i (cable_count_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_count_q <= mbuep_pkg::CableCountW'(1);
      in_valid_q    <= 1'b0;
      state_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cable_count_q <= cfg_wdata_i;
      end
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q  <= byte_i.data_byte;
      in_cable_q <= byte_i.cable;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.outcome    = out_q.outcome;
  assign evt_o.cable_out  = out_q.cable_out;
  assign evt_o.code_index = out_q.code_index;
  assign evt_o.midi_0     = out_q.midi_0;
  assign evt_o.midi_1     = out_q.midi_1;
  assign evt_o.midi_2     = out_q.midi_2;

endmodule
